### sv/kafq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kafq_pkg
// Shared types, codes and helpers of the keyframe-aware frame queue.
// ----------------------------------------------------------------------------
package kafq_pkg;

    localparam int KAFQ_DEPTH      = 16;
    localparam int BURST_THRESHOLD = 4;
    localparam int BURST_LONG      = 3;
    localparam int BURST_SHORT     = 2;
    localparam int IN_DATA_W       = 120;
    localparam int OUT_DATA_W      = 88;

    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    localparam logic [2:0] ST_QUEUED     = 3'd0;
    localparam logic [2:0] ST_NOT_EN     = 3'd1;
    localparam logic [2:0] ST_STALE      = 3'd2;
    localparam logic [2:0] ST_KEY_FLUSH  = 3'd3;
    localparam logic [2:0] ST_AGE_PURGE  = 3'd4;
    localparam logic [2:0] ST_NONKEY_DRP = 3'd5;
    localparam logic [2:0] ST_REJECTED   = 3'd6;

    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_SEND   = 1'b1;

    localparam logic REG_QUEUE_LIMIT = 1'b0;
    localparam logic REG_MAX_AGE     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PURGE_RD,
        S_PURGE_CHK,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH,
        S_EMIT,
        S_POP_RD,
        S_POP_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_IDX,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic [15:0] handle;
        logic [47:0] ftime;
        logic        has_time;
        logic        key;
    } t_entry;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       push;
        logic       clear_occ;
        logic       pop_head;
        logic       dec_occ;
        logic       wr_shift;
        logic       idx_clr;
        logic       idx_inc;
        logic       stale_inc;
        logic       full_inc;
        logic       out_load;
        logic       out_send;
        logic [2:0] out_status;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       link;
        logic       has_ts;
        logic       item_stale;
        logic       is_key;
        logic       occ_zero;
        logic       occ_one;
        logic       occ_lt_lim;
        logic       occ_ge_burst;
        logic       rd_stale;
        logic       rd_key;
        logic       idx_at_end;
        logic       next_at_end;
        logic       out_free;
    } t_stat;

    // Signed 49-bit age difference; a timestamp in the future is never stale.
    function automatic logic is_stale(input logic [47:0] now, input logic [47:0] t,
                                      input logic [15:0] max_age);
        logic [48:0] d;
        d = {1'b0, now} - {1'b0, t};
        return !d[48] && (d[47:0] > {32'd0, max_age});
    endfunction

endpackage
`default_nettype wire

### sv/kafq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kafq_ctrl
// Sequencer for enqueue, purge, scan/shift, send bursts and result beats.
// ----------------------------------------------------------------------------
module kafq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            s_tvalid,
    output logic           s_tready,
    input  kafq_pkg::t_stat i_stat,
    output kafq_pkg::t_cmd  o_cmd
);
    import kafq_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_left, n_left;
    logic       r_purged, n_purged;
    logic       r_dropped, n_dropped;
    logic [2:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_purged  <= 1'b0;
            r_dropped <= 1'b0;
            r_status  <= ST_QUEUED;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_purged  <= n_purged;
            r_dropped <= n_dropped;
            r_status  <= n_status;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_left    = r_left;
        n_purged  = r_purged;
        n_dropped = r_dropped;
        n_status  = r_status;
        o_cmd     = '0;
        o_cmd.rd_sel = RD_HEAD;
        s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.kind == KIND_ENQ) begin
                    n_purged  = 1'b0;
                    n_dropped = 1'b0;
                    priority if (!i_stat.link) begin
                        n_status = ST_NOT_EN;
                        n_state  = S_EMIT;
                    end else if (i_stat.has_ts && i_stat.item_stale) begin
                        n_status = ST_STALE;
                        n_state  = S_EMIT;
                    end else if (i_stat.occ_lt_lim) begin
                        o_cmd.push = 1'b1;
                        n_status   = ST_QUEUED;
                        n_state    = S_EMIT;
                    end else if (i_stat.is_key) begin
                        o_cmd.clear_occ = 1'b1;
                        o_cmd.push      = 1'b1;
                        n_status        = ST_KEY_FLUSH;
                        n_state         = S_EMIT;
                    end else begin
                        n_state = S_PURGE_RD;
                    end
                end else if (i_stat.kind == KIND_SEND) begin
                    if (!i_stat.link || i_stat.occ_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = i_stat.occ_ge_burst ? 2'(BURST_LONG) : 2'(BURST_SHORT);
                        n_state = S_POP_RD;
                    end
                end else if (i_stat.kind == KIND_FLUSH) begin
                    o_cmd.clear_occ = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PURGE_RD: begin
                if (i_stat.occ_zero) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEAD;
                    n_state      = S_PURGE_CHK;
                end
            end
            S_PURGE_CHK: begin
                if (i_stat.rd_stale) begin
                    o_cmd.pop_head  = 1'b1;
                    o_cmd.stale_inc = 1'b1;
                    n_purged        = 1'b1;
                    n_state         = S_PURGE_RD;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.occ_lt_lim) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.idx_at_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_stat.rd_key) begin
                    o_cmd.full_inc = 1'b1;
                    n_dropped      = 1'b1;
                    n_state        = S_SHIFT_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.next_at_end) begin
                    o_cmd.dec_occ = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_FINISH: begin
                if (i_stat.occ_lt_lim) begin
                    o_cmd.push = 1'b1;
                    n_status   = r_dropped ? ST_NONKEY_DRP :
                                 (r_purged ? ST_AGE_PURGE : ST_QUEUED);
                end else begin
                    n_status = ST_REJECTED;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_send   = RK_STATUS;
                    o_cmd.out_status = r_status;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_POP_RD: begin
                if (r_left == 2'd0 || i_stat.occ_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEAD;
                    n_state      = S_POP_EMIT;
                end
            end
            S_POP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_send   = RK_SEND;
                    o_cmd.out_status = ST_QUEUED;
                    o_cmd.out_last   = (r_left == 2'd1) || i_stat.occ_one;
                    o_cmd.pop_head   = 1'b1;
                    n_left           = r_left - 2'd1;
                    n_state          = S_POP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### sv/kafq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kafq_dp
// Descriptor ring memory, pointers, drop counters and the result register.
// ----------------------------------------------------------------------------
module kafq_dp #(
    parameter int QUEUE_DEPTH = kafq_pkg::KAFQ_DEPTH,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  kafq_pkg::t_cmd                    i_cmd,
    input  wire [1:0]                         s_tuser,
    input  wire [kafq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire [4:0]                         i_queue_limit,
    input  wire [15:0]                        i_max_age,
    input  wire                               m_tready,
    output logic                              m_tvalid,
    output logic [kafq_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    output kafq_pkg::t_stat                   o_stat,
    output logic [CW-1:0]                     o_occ
);
    import kafq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int SW = CW + 1;

    t_entry      r_mem [QUEUE_DEPTH];
    t_entry      r_rd;
    logic [1:0]  r_kind;
    logic        r_link;
    logic [15:0] r_handle;
    logic        r_has_ts;
    logic [47:0] r_time;
    logic        r_key;
    logic [47:0] r_now;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_occ, r_idx;
    logic [31:0] r_stale_cnt, r_full_cnt;

    logic        r_o_valid, r_o_kind, r_o_key, r_o_last;
    logic [2:0]  r_o_status;
    logic [15:0] r_o_handle;
    logic [31:0] r_o_stale, r_o_full;

    logic [CW-1:0] w_lim, w_rd_off, w_wr_off;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic          w_wr_en;
    t_entry        w_wr_data;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    always_comb begin
        if (i_queue_limit == 5'd0)                 w_lim = CW'(1);
        else if (32'(i_queue_limit) > QUEUE_DEPTH) w_lim = CW'(QUEUE_DEPTH);
        else                                       w_lim = CW'(i_queue_limit);
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_HEAD: w_rd_off = '0;
            RD_IDX:  w_rd_off = r_idx;
            RD_NEXT: w_rd_off = r_idx + CW'(1);
            default: w_rd_off = '0;
        endcase
        w_rd_addr = ring_addr(r_head, w_rd_off);
        w_wr_off  = i_cmd.wr_shift ? r_idx : (i_cmd.clear_occ ? '0 : r_occ);
        w_wr_addr = ring_addr(r_head, w_wr_off);
        w_wr_en   = i_cmd.push || i_cmd.wr_shift;
        w_wr_data = i_cmd.wr_shift ? r_rd : '{r_handle, r_time, r_has_ts, r_key};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.rd_en) r_rd <= r_mem[w_rd_addr];
    end

    // item latch: link[0] handle[16:1] ts[17] time[65:18] key[66] now[114:67]
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= s_tuser;
            r_link   <= s_tdata[0];
            r_handle <= s_tdata[16:1];
            r_has_ts <= s_tdata[17];
            r_time   <= s_tdata[65:18];
            r_key    <= s_tdata[66];
            r_now    <= s_tdata[114:67];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_stale_cnt <= '0;
            r_full_cnt  <= '0;
        end else begin
            if (i_cmd.pop_head)
                r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            priority if (i_cmd.push && i_cmd.clear_occ) r_occ <= CW'(1);
            else if (i_cmd.clear_occ)                  r_occ <= '0;
            else if (i_cmd.push)                       r_occ <= r_occ + CW'(1);
            else if (i_cmd.pop_head || i_cmd.dec_occ)  r_occ <= r_occ - CW'(1);
            if (i_cmd.idx_clr)      r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
            if (i_cmd.stale_inc) r_stale_cnt <= r_stale_cnt + 32'd1;
            if (i_cmd.full_inc)  r_full_cnt  <= r_full_cnt + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // counters are captured with the beat; the next item may bump them while it waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_kind   <= i_cmd.out_send;
            r_o_status <= i_cmd.out_status;
            r_o_handle <= i_cmd.out_send ? r_rd.handle : 16'd0;
            r_o_key    <= i_cmd.out_send ? r_rd.key : 1'b0;
            r_o_last   <= i_cmd.out_last;
            r_o_stale  <= r_stale_cnt;
            r_o_full   <= r_full_cnt;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tuser  = r_o_kind;
    assign m_tlast  = r_o_last;
    assign m_tdata  = {4'd0, r_o_full, r_o_stale, r_o_key, r_o_handle, r_o_status};
    assign o_occ    = r_occ;

    always_comb begin
        o_stat.kind         = r_kind;
        o_stat.link         = r_link;
        o_stat.has_ts       = r_has_ts;
        o_stat.item_stale   = is_stale(r_now, r_time, i_max_age);
        o_stat.is_key       = r_key;
        o_stat.occ_zero     = (r_occ == '0);
        o_stat.occ_one      = (r_occ == CW'(1));
        o_stat.occ_lt_lim   = (r_occ < w_lim);
        o_stat.occ_ge_burst = (32'(r_occ) >= BURST_THRESHOLD);
        o_stat.rd_stale     = r_rd.has_time && is_stale(r_now, r_rd.ftime, i_max_age);
        o_stat.rd_key       = r_rd.key;
        o_stat.idx_at_end   = (r_idx == r_occ);
        o_stat.next_at_end  = (SW'(r_idx) + SW'(1) >= SW'(r_occ));
        o_stat.out_free     = !r_o_valid || m_tready;
    end

endmodule
`default_nettype wire

### sv/keyframe_aware_frame_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_aware_frame_queue
// Bounded queue of frame descriptors with a key-frame drop policy.
// ----------------------------------------------------------------------------
// Input beats (s_*): tuser = kind (enqueue, send tick, flush); tdata = frame
// descriptor plus current time. One item is worked on at a time; s_tready is
// high only while the sequencer is idle.
// Output beats (m_*): tuser = result kind, tlast = last result of the item.
// An enqueue gives one status beat, a send tick up to three frame beats,
// flush gives none. The result register holds a beat until m_tready.
// Steps per item (one memory port each way): a full non-key enqueue purges
// stale heads, then scans the entries and shifts out the first non-key one;
// a send tick pops frames from the head, or does nothing when the link is
// down or the queue is empty. Reset empties the queue and clears both drop
// counters; the ring memory needs no clearing. Register writes go through
// the APB port; the user is to make them only while idle, as the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module keyframe_aware_frame_queue #(
    parameter int QUEUE_DEPTH = kafq_pkg::KAFQ_DEPTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // link[0] handle[16:1] has_timestamp[17] frame_time[65:18] is_key[66] now_ms[114:67]
    input  wire [kafq_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  wire [1:0]                         s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // status[2:0] out_handle[18:3] out_key[19] stale_drops[51:20] full_drops[83:52]
    output logic [kafq_pkg::OUT_DATA_W-1:0]   m_tdata,
    // result_kind[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [2:0]                         paddr,
    input  wire [31:0]                        pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import kafq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [4:0]    r_queue_limit;
    logic [15:0]   r_max_age;
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [CW-1:0] w_occ;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= 5'd16;
            r_max_age     <= 16'd500;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_QUEUE_LIMIT) r_queue_limit <= pwdata[4:0];
            else                             r_max_age     <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_AGE) ? {16'd0, r_max_age} : {27'd0, r_queue_limit};

    kafq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    kafq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .i_queue_limit (r_queue_limit),
        .i_max_age     (r_max_age),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .o_stat        (w_stat),
        .o_occ         (w_occ)
    );

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_occ) <= QUEUE_DEPTH)
        else $error("occupancy above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (w_stat.occ_lt_lim || w_cmd.clear_occ))
        else $error("push into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.pop_head || w_cmd.dec_occ) |-> !w_stat.occ_zero)
        else $error("removal from empty queue");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result register overwritten");

endmodule
`default_nettype wire
